FILE: rtl/keypad_pin_entry_controller_defines.svh
// Assertion helpers shared by the keypad PIN entry RTL.
`ifndef KEYPAD_PIN_ENTRY_CONTROLLER_DEFINES_SVH
`define KEYPAD_PIN_ENTRY_CONTROLLER_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define KPE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define KPE_NEVER(lbl, cond, msg) \
  `KPE_ASSERT(lbl, !(cond), msg)

`endif

FILE: rtl/kpe_pkg.sv
package kpe_pkg;

  // Key codes
  localparam logic [7:0] KeyZero = 8'h30;
  localparam logic [7:0] KeyNine = 8'h39;
  localparam logic [7:0] KeyStar = 8'h2A;
  localparam logic [7:0] KeyHash = 8'h23;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [2:0] {
    CmdKey     = 3'd0,
    CmdTick    = 3'd1,
    CmdConsume = 3'd2,
    CmdClear   = 3'd3,
    CmdCancel  = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    EvNone      = 3'd0,
    EvKey       = 3'd1,
    EvFull      = 3'd2,
    EvCleared   = 3'd3,
    EvCancelled = 3'd4,
    EvBadLength = 3'd5,
    EvCompleted = 3'd6,
    EvTimeout   = 3'd7
  } event_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgEnable    = 2'd0,
    CfgMinLength = 2'd1,
    CfgMaxLength = 2'd2,
    CfgTimeout   = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] key_char;
  } in_word_t;

  typedef struct packed {
    logic [2:0] event_kind;
    logic [7:0] event_key;
    logic [3:0] event_length;
    logic [3:0] entry_length;
    logic       entry_ready;
    logic       timed_out;
    logic [3:0] pin_digit;
    logic       digit_valid;
    logic       last;
  } out_word_t;

  // Status common to every word caused by one item
  typedef struct packed {
    logic [2:0] event_kind;
    logic [7:0] event_key;
    logic [3:0] event_length;
    logic [3:0] entry_length;
    logic       entry_ready;
    logic       timed_out;
  } status_t;

  // What the entry core hands to the output stage for one item
  typedef struct packed {
    status_t status;
    logic    run;
  } job_t;

endpackage

FILE: rtl/keypad_pin_entry_controller.sv
// Keypad PIN entry controller. Takes one decoded command word per cycle (key,
// millisecond tick, consume, clear, cancel) while no digit run is pending and
// its output register is empty or its word is being taken, and answers with
// status words through that register, so with no output stall words flow back
// to back. Every command gives one word in the cycle after it is taken, except
// consume of a ready entry, which gives one word per stored digit (1 to
// MAX_DIGITS words, one per cycle unless out_stall_i is high); in_stall_o
// stays high until the final digit of such a run sits in the output register
// and can leave. The config port is always ready and must be written only
// while the block is idle; writing enable as one drops any entry in progress.
module keypad_pin_entry_controller import kpe_pkg::*; #(
  parameter int unsigned MAX_DIGITS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_word_t             in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_word_t            out_word_o
);

  localparam int unsigned CntW = $clog2(MAX_DIGITS + 1);

  logic                       accept;
  logic                       free;
  job_t                       job;
  logic [MAX_DIGITS-1:0][3:0] digits;
  logic [CntW-1:0]            count;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = !free;
  assign accept      = in_valid_i && free;

  kpe_core #(
    .MAX_DIGITS (MAX_DIGITS),
    .CntW       (CntW)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_write_i (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .in_word_i   (in_word_i),
    .job_o       (job),
    .digits_o    (digits),
    .count_o     (count)
  );

  kpe_emit #(
    .MAX_DIGITS (MAX_DIGITS),
    .CntW       (CntW)
  ) u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .job_i       (job),
    .digits_i    (digits),
    .count_i     (count),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

FILE: rtl/kpe_core.sv
`include "keypad_pin_entry_controller_defines.svh"

module kpe_core import kpe_pkg::*; #(
  parameter int unsigned MAX_DIGITS = 8,
  parameter int unsigned CntW = $clog2(MAX_DIGITS + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_write_i,
  input  logic [CfgIdxW-1:0]          cfg_index_i,
  input  logic [CfgDataW-1:0]         cfg_data_i,
  input  logic                        accept_i,
  input  in_word_t                    in_word_i,
  output job_t                        job_o,
  output logic [MAX_DIGITS-1:0][3:0]  digits_o,
  output logic [CntW-1:0]             count_o
);

  localparam logic [7:0] MaxD8 = 8'(MAX_DIGITS);

  // Configuration registers
  logic        enable_q;
  logic [3:0]  min_q;
  logic [7:0]  max_q;
  logic [31:0] timeout_q;

  // Entry state
  logic [MAX_DIGITS-1:0][3:0] digits_q, digits_d;
  logic [CntW-1:0]            count_q, count_d;
  logic                       ready_q, ready_d;
  logic                       tflag_q, tflag_d;
  logic [31:0]                idle_q, idle_d;
  logic [2:0]                 rec_kind_q, rec_kind_d;
  logic [7:0]                 rec_key_q, rec_key_d;
  logic [3:0]                 rec_len_q, rec_len_d;

  logic [7:0] eff_max, eff_min;
  logic [7:0] key;
  logic       is_digit;
  logic       run;

  // Clamp the length limits
  always_comb begin
    if (max_q == 8'd0) begin
      eff_max = 8'd1;
    end else if (max_q > MaxD8) begin
      eff_max = MaxD8;
    end else begin
      eff_max = max_q;
    end
    if (min_q == 4'd0) begin
      eff_min = 8'd1;
    end else if (8'(min_q) > eff_max) begin
      eff_min = eff_max;
    end else begin
      eff_min = 8'(min_q);
    end
  end

  assign key      = in_word_i.key_char;
  assign is_digit = (key >= KeyZero) && (key <= KeyNine);

  // Next entry state for the accepted word and for an enable write
  always_comb begin
    digits_d   = digits_q;
    count_d    = count_q;
    ready_d    = ready_q;
    tflag_d    = tflag_q;
    idle_d     = idle_q;
    rec_kind_d = rec_kind_q;
    rec_key_d  = rec_key_q;
    rec_len_d  = rec_len_q;
    run        = 1'b0;

    if (accept_i) begin
      if ((in_word_i.command == CmdConsume) && ready_q) begin
        // Hand the digits to the output stage, then drop the entry
        run      = 1'b1;
        digits_d = '0;
        count_d  = '0;
        ready_d  = 1'b0;
      end else begin
        unique case (in_word_i.command)
          CmdKey: begin
            if (enable_q) begin
              idle_d  = '0;
              tflag_d = 1'b0;
              if (ready_q) begin
                digits_d = '0;
                count_d  = '0;
                ready_d  = 1'b0;
              end
              if (is_digit) begin
                if (8'(count_d) >= eff_max) begin
                  rec_kind_d = EvFull;
                end else begin
                  for (int i = 0; i < MAX_DIGITS; i++) begin
                    if (count_d == CntW'(i)) begin
                      digits_d[i] = 4'(key - KeyZero);
                    end
                  end
                  count_d    = count_d + CntW'(1);
                  rec_kind_d = EvKey;
                end
                rec_key_d = key;
                rec_len_d = 4'(count_d);
              end else if (key == KeyStar) begin
                digits_d   = '0;
                count_d    = '0;
                ready_d    = 1'b0;
                rec_kind_d = EvCleared;
                rec_key_d  = KeyStar;
                rec_len_d  = '0;
              end else if (key == KeyHash) begin
                if ((8'(count_d) < eff_min) || (8'(count_d) > eff_max)) begin
                  digits_d   = '0;
                  count_d    = '0;
                  ready_d    = 1'b0;
                  rec_kind_d = EvBadLength;
                end else begin
                  ready_d    = 1'b1;
                  rec_kind_d = EvCompleted;
                end
                rec_key_d = KeyHash;
                rec_len_d = 4'(count_d);
              end
            end
          end
          CmdTick: begin
            if (enable_q) begin
              idle_d = (idle_q == '1) ? idle_q : idle_q + 32'd1;
              if ((timeout_q != '0) && (count_q != '0) && !ready_q &&
                  (idle_d >= timeout_q)) begin
                digits_d   = '0;
                count_d    = '0;
                ready_d    = 1'b0;
                tflag_d    = 1'b1;
                rec_kind_d = EvTimeout;
                rec_key_d  = '0;
                rec_len_d  = '0;
              end
            end
          end
          CmdClear, CmdCancel: begin
            digits_d   = '0;
            count_d    = '0;
            ready_d    = 1'b0;
            rec_kind_d = (in_word_i.command == CmdClear) ? EvCleared : EvCancelled;
            rec_key_d  = KeyStar;
            rec_len_d  = '0;
          end
          default: begin
          end
        endcase
      end
    end

    // Enabling drops the entry
    if (cfg_write_i && (cfg_index_i == CfgEnable) && cfg_data_i[0]) begin
      digits_d = '0;
      count_d  = '0;
      ready_d  = 1'b0;
    end
  end

  // Status after the item
  assign job_o.run                 = run;
  assign job_o.status.event_kind   = rec_kind_d;
  assign job_o.status.event_key    = rec_key_d;
  assign job_o.status.event_length = rec_len_d;
  assign job_o.status.entry_length = 4'(count_d);
  assign job_o.status.entry_ready  = ready_d;
  assign job_o.status.timed_out    = tflag_d;
  assign digits_o = digits_q;
  assign count_o  = count_q;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q  <= 1'b0;
      min_q     <= 4'd1;
      max_q     <= 8'd8;
      timeout_q <= '0;
    end else if (cfg_write_i) begin
      unique case (cfg_index_i)
        CfgEnable:    enable_q  <= cfg_data_i[0];
        CfgMinLength: min_q     <= cfg_data_i[3:0];
        CfgMaxLength: max_q     <= cfg_data_i[7:0];
        CfgTimeout:   timeout_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Hold entry state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digits_q   <= '0;
      count_q    <= '0;
      ready_q    <= 1'b0;
      tflag_q    <= 1'b0;
      idle_q     <= '0;
      rec_kind_q <= EvNone;
      rec_key_q  <= '0;
      rec_len_q  <= '0;
    end else begin
      digits_q   <= digits_d;
      count_q    <= count_d;
      ready_q    <= ready_d;
      tflag_q    <= tflag_d;
      idle_q     <= idle_d;
      rec_kind_q <= rec_kind_d;
      rec_key_q  <= rec_key_d;
      rec_len_q  <= rec_len_d;
    end
  end

  `KPE_ASSERT(a_ready_has_digits, ready_q |-> (count_q != '0), "ready entry with no digits")
  `KPE_NEVER(a_ready_not_timed_out, ready_q && tflag_q, "ready and timed out together")
  `KPE_ASSERT(a_count_bound, 32'(count_q) <= MAX_DIGITS, "digit count beyond store")

endmodule

FILE: rtl/kpe_emit.sv
`include "keypad_pin_entry_controller_defines.svh"

module kpe_emit import kpe_pkg::*; #(
  parameter int unsigned MAX_DIGITS = 8,
  parameter int unsigned CntW = $clog2(MAX_DIGITS + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        load_i,
  input  job_t                        job_i,
  input  logic [MAX_DIGITS-1:0][3:0]  digits_i,
  input  logic [CntW-1:0]             count_i,
  output logic                        free_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output out_word_t                   out_word_o
);

  logic                       out_valid_q, out_valid_d;
  out_word_t                  out_q, out_d;
  logic [MAX_DIGITS-1:0][3:0] run_q, run_d;
  logic [CntW-1:0]            rem_q, rem_d;
  logic                       taken;

  assign taken  = out_valid_q && !out_stall_i;
  assign free_o = (rem_q == '0) && (!out_valid_q || !out_stall_i);

  // Load a new word, or step through the digit run
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    run_d       = run_q;
    rem_d       = rem_q;
    if (load_i) begin
      out_valid_d           = 1'b1;
      out_d.event_kind      = job_i.status.event_kind;
      out_d.event_key       = job_i.status.event_key;
      out_d.event_length    = job_i.status.event_length;
      out_d.entry_length    = job_i.status.entry_length;
      out_d.entry_ready     = job_i.status.entry_ready;
      out_d.timed_out       = job_i.status.timed_out;
      if (job_i.run && (count_i != '0)) begin
        out_d.pin_digit   = digits_i[0];
        out_d.digit_valid = 1'b1;
        out_d.last        = (count_i == CntW'(1));
        for (int i = 0; i < MAX_DIGITS - 1; i++) begin
          run_d[i] = digits_i[i+1];
        end
        run_d[MAX_DIGITS-1] = '0;
        rem_d = count_i - CntW'(1);
      end else begin
        out_d.pin_digit   = '0;
        out_d.digit_valid = 1'b0;
        out_d.last        = 1'b1;
        rem_d             = '0;
      end
    end else if (taken) begin
      if (rem_q != '0) begin
        out_d.pin_digit   = run_q[0];
        out_d.digit_valid = 1'b1;
        out_d.last        = (rem_q == CntW'(1));
        for (int i = 0; i < MAX_DIGITS - 1; i++) begin
          run_d[i] = run_q[i+1];
        end
        run_d[MAX_DIGITS-1] = '0;
        rem_d = rem_q - CntW'(1);
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      rem_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      rem_q       <= rem_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    run_q <= run_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  `KPE_ASSERT(a_run_shown, (rem_q != '0) |-> out_valid_q, "pending digits without a word shown")
  `KPE_ASSERT(a_last_closes_run, (out_valid_q && !out_q.last) |-> (rem_q != '0),
              "non-final word with no digits left")
  `KPE_ASSERT(a_status_only_last, (out_valid_q && !out_q.digit_valid) |-> out_q.last,
              "status word not marked last")

endmodule

FILE: tb/sv/keypad_pin_entry_controller_tb.sv
module keypad_pin_entry_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kpe_pkg::*;

  localparam int unsigned MaxDigits    = 8;
  localparam int unsigned PhaseWords   = 42;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned DrainLimit   = 100000;
  localparam int unsigned RunLimitNs   = 5_000_000;

  // Command code the block must ignore, and a key that is neither digit nor control
  localparam logic [2:0] CmdSpare   = 3'd7;
  localparam logic [7:0] KeyLetterA = 8'h41;

  typedef struct {
    bit          is_cfg;
    cfg_reg_e    cfg_idx;
    logic [31:0] cfg_val;
    in_word_t    word;
    bit          typed;
    out_word_t   want;
  } plan_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  in_word_t            in_word_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_word_t           out_word_o;

  keypad_pin_entry_controller #(
    .MAX_DIGITS(MaxDigits)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  // Shadow copy of the entry state and settings
  logic [3:0]  pin_digits [MaxDigits];
  logic [3:0]  pin_count;
  logic        pin_ready;
  logic        timed_flag;
  logic [31:0] idle_ms;
  event_e      ev_kind;
  logic [7:0]  ev_key;
  logic [3:0]  ev_len;
  logic        cfg_en;
  logic [3:0]  cfg_min;
  logic [7:0]  cfg_max;
  logic [31:0] cfg_tmo;

  out_word_t   expected_words [$];
  plan_row_t   plan [$];
  out_word_t   oldest;
  int          mismatches = 0;
  int unsigned words_sent = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs
  initial begin
    #(RunLimitNs);
    $display("Mismatches found");
    $finish;
  end

  function automatic in_word_t in_word(logic [2:0] cmd, logic [7:0] key);
    in_word_t w;
    w.command  = cmd;
    w.key_char = key;
    return w;
  endfunction

  function automatic void drop_entry();
    foreach (pin_digits[i]) pin_digits[i] = '0;
    pin_count = '0;
    pin_ready = 1'b0;
  endfunction

  function automatic void note_event(event_e kind, logic [7:0] key);
    ev_kind = kind;
    ev_key  = key;
    ev_len  = pin_count;
  endfunction

  function automatic void reset_model();
    drop_entry();
    timed_flag = 1'b0;
    idle_ms    = '0;
    ev_kind    = EvNone;
    ev_key     = '0;
    ev_len     = '0;
    cfg_en     = 1'b0;
    cfg_min    = 4'd1;
    cfg_max    = 8'd8;
    cfg_tmo    = '0;
  endfunction

  // Effective length limits after clamping
  function automatic int unsigned top_len();
    int unsigned m;
    m = cfg_max;
    if (m == 0) m = 1;
    if (m > MaxDigits) m = MaxDigits;
    return m;
  endfunction

  function automatic int unsigned floor_len();
    int unsigned m;
    m = cfg_min;
    if (m == 0) m = 1;
    if (m > top_len()) m = top_len();
    return m;
  endfunction

  function automatic out_word_t status_word(logic [3:0] digit, logic dv, logic lst);
    out_word_t o;
    o.event_kind   = ev_kind;
    o.event_key    = ev_key;
    o.event_length = ev_len;
    o.entry_length = pin_count;
    o.entry_ready  = pin_ready;
    o.timed_out    = timed_flag;
    o.pin_digit    = digit;
    o.digit_valid  = dv;
    o.last         = lst;
    return o;
  endfunction

  function automatic out_word_t status_lit(event_e kind, logic [7:0] key, logic [3:0] elen,
                                           logic [3:0] len, logic rdy, logic tmo);
    out_word_t o;
    o = '0;
    o.event_kind   = kind;
    o.event_key    = key;
    o.event_length = elen;
    o.entry_length = len;
    o.entry_ready  = rdy;
    o.timed_out    = tmo;
    o.last         = 1'b1;
    return o;
  endfunction

  function automatic void apply_key(logic [7:0] key);
    idle_ms    = '0;
    timed_flag = 1'b0;
    if (pin_ready) drop_entry();
    if (key >= KeyZero && key <= KeyNine) begin
      if (pin_count >= top_len()) begin
        note_event(EvFull, key);
      end else begin
        pin_digits[pin_count] = 4'(key - KeyZero);
        pin_count = pin_count + 4'd1;
        note_event(EvKey, key);
      end
    end else if (key == KeyStar) begin
      drop_entry();
      note_event(EvCleared, KeyStar);
    end else if (key == KeyHash) begin
      if (pin_count < floor_len() || pin_count > top_len()) begin
        drop_entry();
        note_event(EvBadLength, KeyHash);
      end else begin
        pin_ready = 1'b1;
        note_event(EvCompleted, KeyHash);
      end
    end
  endfunction

  function automatic void count_tick();
    if (idle_ms != '1) idle_ms = idle_ms + 32'd1;
    if (cfg_tmo != 0 && pin_count != 0 && !pin_ready && idle_ms >= cfg_tmo) begin
      drop_entry();
      timed_flag = 1'b1;
      note_event(EvTimeout, 8'h00);
    end
  endfunction

  // Queue the words one accepted command word should produce
  function automatic void predict_item(in_word_t w);
    logic [3:0]  run [MaxDigits];
    int unsigned n;
    if (w.command == CmdConsume && pin_ready) begin
      run = pin_digits;
      n   = pin_count;
      drop_entry();
      if (n == 0) expected_words.push_back(status_word(4'd0, 1'b0, 1'b1));
      for (int i = 0; i < n; i++)
        expected_words.push_back(status_word(run[i], 1'b1, i == n - 1));
    end else begin
      case (w.command)
        CmdKey:    if (cfg_en) apply_key(w.key_char);
        CmdTick:   if (cfg_en) count_tick();
        CmdClear:  begin
          drop_entry();
          note_event(EvCleared, KeyStar);
        end
        CmdCancel: begin
          drop_entry();
          note_event(EvCancelled, KeyStar);
        end
        default: ;
      endcase
      expected_words.push_back(status_word(4'd0, 1'b0, 1'b1));
    end
  endfunction

  function automatic void predict_cfg(cfg_reg_e idx, logic [31:0] val);
    case (idx)
      CfgEnable:    begin
        cfg_en = val[0];
        if (val[0]) drop_entry();
      end
      CfgMinLength: cfg_min = val[3:0];
      CfgMaxLength: cfg_max = val[7:0];
      CfgTimeout:   cfg_tmo = val;
      default: ;
    endcase
  endfunction

  function automatic string show_word(out_word_t o);
    return $sformatf("kind=%0d key=%02h elen=%0d len=%0d rdy=%0b tmo=%0b dig=%0d dv=%0b last=%0b",
                     o.event_kind, o.event_key, o.event_length, o.entry_length,
                     o.entry_ready, o.timed_out, o.pin_digit, o.digit_valid, o.last);
  endfunction

  function automatic void add_cfg(cfg_reg_e idx, logic [31:0] val);
    plan_row_t r;
    r.is_cfg  = 1'b1;
    r.cfg_idx = idx;
    r.cfg_val = val;
    r.word    = '0;
    r.typed   = 1'b0;
    r.want    = '0;
    plan.push_back(r);
  endfunction

  function automatic void add_word(logic [2:0] cmd, logic [7:0] key, bit typed, out_word_t want);
    plan_row_t r;
    r.is_cfg  = 1'b0;
    r.cfg_idx = CfgEnable;
    r.cfg_val = '0;
    r.word    = in_word(cmd, key);
    r.typed   = typed;
    r.want    = want;
    plan.push_back(r);
  endfunction

  // Directed rows: disabled block, key kinds, full buffer, consume, timeout, shrunk limits
  function automatic void build_plan();
    out_word_t quiet;
    quiet = status_lit(EvNone, 8'h00, 4'd0, 4'd0, 1'b0, 1'b0);
    add_cfg(CfgEnable, 32'd0);
    add_word(CmdKey, KeyZero + 8'd5, 1'b1, quiet);
    add_word(CmdTick, 8'h00, 1'b1, quiet);
    add_word(CmdConsume, KeyHash, 1'b1, quiet);
    add_word(CmdSpare, 8'hFF, 1'b1, quiet);
    add_cfg(CfgEnable, 32'd1);
    add_word(CmdKey, KeyZero, 1'b1, status_lit(EvKey, KeyZero, 4'd1, 4'd1, 1'b0, 1'b0));
    add_word(CmdKey, KeyLetterA, 1'b1, status_lit(EvKey, KeyZero, 4'd1, 4'd1, 1'b0, 1'b0));
    add_word(CmdKey, KeyStar, 1'b1, status_lit(EvCleared, KeyStar, 4'd0, 4'd0, 1'b0, 1'b0));
    add_word(CmdKey, KeyHash, 1'b1, status_lit(EvBadLength, KeyHash, 4'd0, 4'd0, 1'b0, 1'b0));
    for (int d = 1; d <= MaxDigits; d++) add_word(CmdKey, KeyZero + 8'(d), 1'b0, '0);
    add_word(CmdKey, KeyNine, 1'b1, status_lit(EvFull, KeyNine, 4'd8, 4'd8, 1'b0, 1'b0));
    add_word(CmdKey, KeyHash, 1'b1, status_lit(EvCompleted, KeyHash, 4'd8, 4'd8, 1'b1, 1'b0));
    add_word(CmdConsume, 8'h00, 1'b0, '0);
    add_word(CmdCancel, 8'h55, 1'b1, status_lit(EvCancelled, KeyStar, 4'd0, 4'd0, 1'b0, 1'b0));
    add_cfg(CfgTimeout, 32'd2);
    add_word(CmdKey, KeyZero + 8'd1, 1'b0, '0);
    add_word(CmdTick, 8'h00, 1'b0, '0);
    add_word(CmdTick, 8'h00, 1'b1, status_lit(EvTimeout, 8'h00, 4'd0, 4'd0, 1'b0, 1'b1));
    add_word(CmdKey, KeyZero + 8'd2, 1'b0, '0);
    add_word(CmdKey, KeyZero + 8'd3, 1'b1,
             status_lit(EvKey, KeyZero + 8'd3, 4'd2, 4'd2, 1'b0, 1'b0));
    // shrink the limits below the two digits already held
    add_cfg(CfgMaxLength, 32'd0);
    add_cfg(CfgMinLength, 32'd15);
    add_cfg(CfgTimeout, 32'hFFFF_FFFF);
    add_word(CmdKey, KeyZero + 8'd4, 1'b1,
             status_lit(EvFull, KeyZero + 8'd4, 4'd2, 4'd2, 1'b0, 1'b0));
    add_word(CmdKey, KeyHash, 1'b1, status_lit(EvBadLength, KeyHash, 4'd0, 4'd0, 1'b0, 1'b0));
    add_word(CmdClear, 8'hAA, 1'b1, status_lit(EvCleared, KeyStar, 4'd0, 4'd0, 1'b0, 1'b0));
  endfunction

  // Offer one command word, hold it until taken, then predict its answer
  task automatic send_word(in_word_t w);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    predict_item(w);
    words_sent++;
  endtask

  // Write a register once every answer is out and the block has settled
  task automatic write_cfg(cfg_reg_e idx, logic [31:0] val);
    in_valid_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
    predict_cfg(idx, val);
  endtask

  task automatic tick_burst(int unsigned n);
    repeat (n) send_word(in_word(CmdTick, 8'($urandom_range(0, 255))));
  endtask

  // Digits, maybe some idle time, submit, then mostly consume
  task automatic enter_pin();
    int unsigned digits_n;
    int unsigned pick;
    digits_n = $urandom_range(0, MaxDigits + 1);
    for (int d = 0; d < digits_n; d++) begin
      send_word(in_word(CmdKey, KeyZero + 8'($urandom_range(0, 9))));
      if ($urandom_range(0, 9) == 0) tick_burst($urandom_range(1, 4));
    end
    if ($urandom_range(0, 99) < 85) send_word(in_word(CmdKey, KeyHash));
    pick = $urandom_range(0, 99);
    if (pick < 65) send_word(in_word(CmdConsume, 8'($urandom_range(0, 255))));
    else if (pick < 80) send_word(in_word(CmdKey, 8'($urandom_range(0, 255))));
  endtask

  // Random back-pressure on the answer side
  always @(posedge clk_i) out_stall_i <= ($urandom_range(0, 99) < stall_pct);

  // Compare each taken answer word with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected output word: %s", $time, show_word(out_word_o));
        mismatches++;
      end else begin
        oldest = expected_words.pop_front();
        if (out_word_o !== oldest) begin
          $display("%0t: output word mismatch: expected %s, got %s", $time,
                   show_word(oldest), show_word(out_word_o));
          mismatches++;
        end
      end
    end
  end

  initial begin
    int unsigned pick;
    bit          mid_done;
    reset_model();
    build_plan();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed rows
    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        write_cfg(plan[i].cfg_idx, plan[i].cfg_val);
      end else begin
        send_word(plan[i].word);
        if (plan[i].typed) begin
          void'(expected_words.pop_back());
          expected_words.push_back(plan[i].want);
        end
      end
    end

    // Random phases with different idling and settings
    for (int p = 0; p < 4; p++) begin
      write_cfg(CfgEnable, 32'd1);
      case (p)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
          write_cfg(CfgMinLength, 32'd1);
          write_cfg(CfgMaxLength, 32'd8);
          write_cfg(CfgTimeout, 32'd0);
        end
        1: begin
          send_idle_pct = 64;
          stall_pct     = 0;
          write_cfg(CfgMinLength, 32'd0);
          write_cfg(CfgMaxLength, 32'd255);
          write_cfg(CfgTimeout, 32'd3);
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 64;
          write_cfg(CfgMinLength, 32'd15);
          write_cfg(CfgMaxLength, 32'd4);
          write_cfg(CfgTimeout, $urandom_range(1, 8));
        end
        default: begin
          send_idle_pct = 35;
          stall_pct     = 35;
          write_cfg(CfgMinLength, $urandom_range(0, 15));
          write_cfg(CfgMaxLength, $urandom_range(0, 10));
          write_cfg(CfgTimeout, 32'hFFFF_FFFF);
        end
      endcase
      words_sent = 0;
      mid_done   = 1'b0;
      while (words_sent < PhaseWords) begin
        // change the limits midway, leaving any partial entry in place
        if (!mid_done && words_sent >= PhaseWords / 2) begin
          write_cfg(CfgMinLength, $urandom_range(0, 15));
          write_cfg(CfgMaxLength, ($urandom_range(0, 3) == 0) ? 32'd255 : $urandom_range(0, 10));
          write_cfg(CfgTimeout, $urandom_range(0, 6));
          mid_done = 1'b1;
        end
        pick = $urandom_range(0, 99);
        if (pick < 60) enter_pin();
        else if (pick < 75) tick_burst($urandom_range(1, 8));
        else send_word(in_word(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255))));
      end
    end

    // Drain the remaining answers
    in_valid_i <= 1'b0;
    for (int c = 0; c < DrainLimit && expected_words.size() != 0; c++) @(posedge clk_i);
    repeat (SettleCycles * 4) @(posedge clk_i);
    if (expected_words.size() != 0) begin
      $display("%0t: %0d expected output words never arrived", $time, expected_words.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/kpe_pkg.sv
rtl/kpe_core.sv
rtl/kpe_emit.sv
rtl/keypad_pin_entry_controller.sv
tb/sv/keypad_pin_entry_controller_tb.sv
